// ----- rtl/core/arsf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// arsf_pkg
// Shared types and constants of the alarm repeat suppression filter.
// ----------------------------------------------------------------------------
package arsf_pkg;

    localparam int unsigned DEF_TABLE_SLOTS = 64;

    localparam int unsigned INDEX_W = 16;
    localparam int unsigned SEV_W   = 3;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned CFG_W   = 32;

    localparam logic [CFG_W-1:0] RST_FILTER_WINDOW  = 32'd5000;
    localparam logic [CFG_W-1:0] RST_SWEEP_INTERVAL = 32'd60000;

    // register indexes on the configuration port
    localparam logic REG_FILTER_WINDOW  = 1'b0;
    localparam logic REG_SWEEP_INTERVAL = 1'b1;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic [SEV_W-1:0]   alarm_severity;
        logic [INDEX_W-1:0] alarm_index;
    } item_t;

    typedef struct packed {
        logic table_full;
        logic suppressed;
    } result_t;

    // one table slot as stored in memory
    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] alarm_index;
        logic [SEV_W-1:0]   alarm_severity;
        logic [TIME_W-1:0]  issue_time;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- rtl/core/arsf_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// arsf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arsf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/arsf_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// arsf_engine
// Sequencer around the slot table: clearing pass, scan with sweep and lookup,
// and the final update of the hit or free slot.
// ----------------------------------------------------------------------------
module arsf_engine #(
    parameter int unsigned SLOTS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [arsf_pkg::CFG_W-1:0]      filter_window,
    input  wire logic [arsf_pkg::CFG_W-1:0]      sweep_interval,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire arsf_pkg::item_t                 item,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output arsf_pkg::result_t                    res,
    output logic                                 ram_we,
    output logic [$clog2(SLOTS)-1:0]             ram_waddr,
    output logic [arsf_pkg::ENTRY_W-1:0]         ram_wdata,
    output logic                                 ram_re,
    output logic [$clog2(SLOTS)-1:0]             ram_raddr,
    input  wire logic [arsf_pkg::ENTRY_W-1:0]    ram_rdata
);

    import arsf_pkg::*;

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       cnt_reg;
    item_t               item_reg;
    logic                sweep_reg;
    logic [TIME_W-1:0]   next_sweep_reg;
    logic                rd_vld_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic                hit_found_reg;
    logic                hit_stale_reg;
    logic [AW-1:0]       hit_addr_reg;
    logic                free_found_reg;
    logic [AW-1:0]       free_addr_reg;

    entry_t              entry;
    entry_t              new_entry;
    logic                entry_stale;
    logic                entry_live;
    logic                key_match;
    logic                scan_more;
    logic                do_sweep;
    logic [TIME_W:0]     sweep_sum;
    logic [TIME_W-1:0]   next_sweep_next;

    always_comb
    begin
        entry       = entry_t'(ram_rdata);
        entry_stale = {1'b0, item_reg.now_ms} >
                      ({1'b0, entry.issue_time} + (TIME_W+1)'(filter_window));
        entry_live  = entry.valid && !(sweep_reg && entry_stale);
        key_match   = (entry.alarm_index == item_reg.alarm_index) &&
                      (entry.alarm_severity == item_reg.alarm_severity);
        scan_more   = (cnt_reg != CW'(SLOTS));

        // sweep decision and new sweep time, saturating at the top of the time range
        do_sweep  = item.now_ms > next_sweep_reg;
        sweep_sum = {1'b0, item.now_ms} + (TIME_W+1)'(sweep_interval);
        next_sweep_next = sweep_sum[TIME_W] ? '1 : sweep_sum[TIME_W-1:0];

        new_entry.valid          = 1'b1;
        new_entry.alarm_index    = item_reg.alarm_index;
        new_entry.alarm_severity = item_reg.alarm_severity;
        new_entry.issue_time     = item_reg.now_ms;
    end

    // memory ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = '0;
        priority if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (rd_vld_reg && entry.valid && !entry_live)
        begin
            // entry swept out: drop its valid bit
            ram_we    = 1'b1;
            ram_waddr = rd_addr_reg;
            ram_wdata = ENTRY_W'({1'b0, entry.alarm_index, entry.alarm_severity,
                                  entry.issue_time});
        end
        else if (state_reg == ST_UPDATE &&
                 (hit_found_reg ? hit_stale_reg : free_found_reg))
        begin
            ram_we    = 1'b1;
            ram_waddr = hit_found_reg ? hit_addr_reg : free_addr_reg;
            ram_wdata = ENTRY_W'(new_entry);
        end
        else
        begin
            ram_we = 1'b0;
        end
        ram_re    = (state_reg == ST_SCAN) && scan_more;
        ram_raddr = cnt_reg[AW-1:0];
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_RESULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            next_sweep_reg <= '0;
            sweep_reg      <= 1'b0;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            hit_stale_reg  <= 1'b0;
            hit_addr_reg   <= '0;
            free_addr_reg  <= '0;
            rd_addr_reg    <= '0;
            item_reg       <= '0;
            res            <= '0;
        end
        else
        begin
            rd_vld_reg  <= ram_re;
            rd_addr_reg <= ram_raddr;

            // scan results, taken in slot order
            if (rd_vld_reg)
            begin
                if (entry_live && key_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_addr_reg  <= rd_addr_reg;
                    hit_stale_reg <= entry_stale;
                end
                if (!entry_live && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_addr_reg  <= rd_addr_reg;
                end
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (cnt_reg[AW-1:0] == AW'(SLOTS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        item_reg       <= item;
                        sweep_reg      <= do_sweep;
                        if (do_sweep)
                        begin
                            next_sweep_reg <= next_sweep_next;
                        end
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        cnt_reg        <= '0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_more)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    res.suppressed <= hit_found_reg && !hit_stale_reg;
                    res.table_full <= !hit_found_reg && !free_found_reg;
                    state_reg      <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/alarm_repeat_suppression_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_repeat_suppression_filter
// Time-window suppression of repeated alarm events, keyed by index/severity.
// ----------------------------------------------------------------------------
// One event word in gives one result word out. The slot table lives in a
// single RAM (valid, key and issue time per slot) that is walked one slot per
// cycle: the walk drops stale slots when a sweep is due and looks up the key
// in the same pass, then the update state writes the refreshed or new slot.
// The block takes no new event until the last one has been scanned, written
// and its result handed on, as the slot RAM has a single read port. After
// reset the block clears every slot of the RAM before it takes the first
// event; configuration writes are taken at any time but should only change
// settings while no event is in flight. The result sits in an output
// register, so the next event is taken while it waits.
// ----------------------------------------------------------------------------
module alarm_repeat_suppression_filter #(
    parameter int unsigned TABLE_SLOTS = arsf_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [arsf_pkg::CFG_W-1:0]          cfg_data,
    // events in
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [15:0] alarm_index, [18:16] alarm_severity, [66:19] now_ms
    input  wire logic [arsf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // results out
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] suppressed, [1] table_full
    output logic [arsf_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    import arsf_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_SLOTS);

    logic [CFG_W-1:0]   filter_window_reg;
    logic [CFG_W-1:0]   sweep_interval_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;

    item_t              item;
    result_t            eng_res;
    logic               eng_res_valid;
    logic               out_free;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign item = item_t'(s_tdata[$bits(item_t)-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_window_reg  <= RST_FILTER_WINDOW;
            sweep_interval_reg <= RST_SWEEP_INTERVAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_WINDOW:  filter_window_reg  <= cfg_data;
                REG_SWEEP_INTERVAL: sweep_interval_reg <= cfg_data;
                default:            filter_window_reg  <= filter_window_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else if (out_free)
        begin
            out_valid_reg <= eng_res_valid;
            if (eng_res_valid)
            begin
                out_res_reg <= eng_res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_res_reg);

    arsf_engine #(
        .SLOTS (TABLE_SLOTS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .filter_window  (filter_window_reg),
        .sweep_interval (sweep_interval_reg),
        .item_valid     (s_tvalid),
        .item_ready     (s_tready),
        .item           (item),
        .res_valid      (eng_res_valid),
        .res_ready      (out_free),
        .res            (eng_res),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    arsf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ----- verif/alarm_repeat_suppression_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_repeat_suppression_filter_tb
// Checks repeat suppression, stale refresh, sweeps and table overflow. Events
// go in as random bursts. Results come back under receiver back-pressure and
// are compared with a scoreboard that keeps its own copy of the slot table.
// ----------------------------------------------------------------------------
module alarm_repeat_suppression_filter_tb;

    import arsf_pkg::*;

    localparam int unsigned SLOTS       = DEF_TABLE_SLOTS;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned POOL_KEYS   = 6;
    localparam logic [63:0] TIME_MAX    = 64'h0000_FFFF_FFFF_FFFF;

    // predicts the verdict of each accepted event and holds it until its word
    // comes back
    class suppression_scoreboard;
        logic [CFG_W-1:0]   window;
        logic [CFG_W-1:0]   interval;
        bit                 live [SLOTS];
        logic [INDEX_W-1:0] key_idx [SLOTS];
        logic [SEV_W-1:0]   key_sev [SLOTS];
        logic [TIME_W-1:0]  stamp [SLOTS];
        logic [TIME_W-1:0]  sweep_due;
        result_t            verdicts [$];
        int unsigned        errors;

        function new();
            window    = RST_FILTER_WINDOW;
            interval  = RST_SWEEP_INTERVAL;
            sweep_due = '0;
            errors    = 0;
            foreach (live[i])
                live[i] = 1'b0;
        endfunction

        function bit expired(logic [TIME_W-1:0] now, logic [TIME_W-1:0] issued);
            return {16'b0, now} > ({16'b0, issued} + {32'b0, window});
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_FILTER_WINDOW)
                window = val;
            else
                interval = val;
        endfunction

        function void note_event(item_t ev);
            int          hit;
            int          spare;
            logic [63:0] due;
            result_t     verdict;
            hit     = -1;
            spare   = -1;
            verdict = '0;
            if (ev.now_ms > sweep_due)
            begin
                due       = {16'b0, ev.now_ms} + {32'b0, interval};
                sweep_due = (due > TIME_MAX) ? '1 : due[TIME_W-1:0];
                foreach (live[i])
                    if (live[i] && expired(ev.now_ms, stamp[i]))
                        live[i] = 1'b0;
            end
            foreach (live[i])
            begin
                if (live[i])
                begin
                    if (hit < 0 && key_idx[i] == ev.alarm_index
                        && key_sev[i] == ev.alarm_severity)
                        hit = i;
                end
                else if (spare < 0)
                    spare = i;
            end
            if (hit >= 0)
            begin
                if (expired(ev.now_ms, stamp[hit]))
                    stamp[hit] = ev.now_ms;
                else
                    verdict.suppressed = 1'b1;
            end
            else if (spare >= 0)
            begin
                live[spare]    = 1'b1;
                key_idx[spare] = ev.alarm_index;
                key_sev[spare] = ev.alarm_severity;
                stamp[spare]   = ev.now_ms;
            end
            else
                verdict.table_full = 1'b1;
            verdicts.push_back(verdict);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (verdicts.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got %b", $time, got);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (got.suppressed !== want.suppressed)
            begin
                $display("%0t: suppressed mismatch, expected %b, got %b",
                         $time, want.suppressed, got.suppressed);
                errors++;
            end
            if (got.table_full !== want.table_full)
            begin
                $display("%0t: table_full mismatch, expected %b, got %b",
                         $time, want.table_full, got.table_full);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    suppression_scoreboard board = new();

    int unsigned        cycle_count = 0;
    int unsigned        rx_count = 0;
    int unsigned        burst_left = 0;
    logic [TIME_W-1:0]  clock_ms = '0;
    logic [INDEX_W-1:0] pool_idx [POOL_KEYS];
    logic [SEV_W-1:0]   pool_sev [POOL_KEYS];

    alarm_repeat_suppression_filter #(
        .TABLE_SLOTS (SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: stall style follows bits [9:8] of the free-running rx_count
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(result_t'(m_tdata[1:0]));
        rx_count <= rx_count + 1;
        case (rx_count[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rx_count[3:0] < 4'd4);
        endcase
    end

    function automatic item_t build_event(logic [INDEX_W-1:0] idx, logic [SEV_W-1:0] sev,
                                          logic [TIME_W-1:0] now);
        item_t ev;
        ev.alarm_index    = idx;
        ev.alarm_severity = sev;
        ev.now_ms         = now;
        return ev;
    endfunction

    // leaves tvalid high unless a gap follows, so the caller must send again
    // or lower tvalid in the same step
    task automatic send_event(input item_t ev);
        logic [IN_TDATA_W-1:0] word;
        int unsigned           gap;
        int unsigned           roll;
        word                         = '0;
        word[$bits(item_t)-1:0]      = ev;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_event(ev);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                gap = $urandom_range(1, 6);
            else if (roll < 90)
                gap = $urandom_range(7, 40);
            else
                gap = $urandom_range(41, 90);
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 11);
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] ivl);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FILTER_WINDOW;
        cfg_data  <= win;
        @(posedge clk);
        cfg_index <= REG_SWEEP_INTERVAL;
        cfg_data  <= ivl;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_register(REG_FILTER_WINDOW, win);
        board.set_register(REG_SWEEP_INTERVAL, ivl);
    endtask

    // mostly a small pool of repeating keys on an advancing clock, with fresh
    // keys, late timestamps and (in wild phases) arbitrary times mixed in
    task automatic run_phase(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] ivl,
                             input int count, input int unsigned step_max,
                             input int fresh_pct, input logic [TIME_W-1:0] leap,
                             input bit wild);
        int                 k;
        int unsigned        pick;
        int unsigned        roll;
        logic [63:0]        wide;
        logic [INDEX_W-1:0] idx;
        logic [SEV_W-1:0]   sev;
        logic [TIME_W-1:0]  now;
        drain();
        write_config(win, ivl);
        for (k = 0; k < POOL_KEYS; k++)
        begin
            pool_idx[k] = INDEX_W'($urandom);
            pool_sev[k] = SEV_W'($urandom);
        end
        clock_ms += leap;
        if (wild)
        begin
            wide     = {$urandom, $urandom};
            clock_ms = {1'b0, wide[46:0]};
        end
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, POOL_KEYS - 1);
            idx  = pool_idx[pick];
            sev  = pool_sev[pick];
            if ($urandom_range(0, 99) < fresh_pct)
            begin
                idx = INDEX_W'($urandom);
                sev = SEV_W'($urandom);
            end
            clock_ms += TIME_W'($urandom_range(0, step_max));
            now  = clock_ms;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                now = (clock_ms > 300) ? clock_ms - TIME_W'($urandom_range(0, 300)) : '0;
            else if (wild && roll < 15)
            begin
                wide = {$urandom, $urandom};
                now  = wide[TIME_W-1:0];
            end
            send_event(build_event(idx, sev, now));
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FILTER_WINDOW;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: window 5000, sweep interval 60000
        send_event(build_event(16'h0000, 3'd0, 48'd0));
        send_event(build_event(16'h0000, 3'd0, 48'd0));      // repeat at same time
        send_event(build_event(16'hFFFF, 3'd7, 48'd5000));
        send_event(build_event(16'h0000, 3'd0, 48'd5000));   // window edge, still held
        send_event(build_event(16'h0000, 3'd0, 48'd5001));   // past the window: stale hit, refresh
        send_event(build_event(16'hFFFF, 3'd7, 48'd100));    // clock ran backwards
        send_event(build_event(16'h0000, 3'd0, 48'd11000));  // stale hit, refresh
        send_event(build_event(16'h0000, 3'd0, 48'd11000));
        send_event(build_event(16'h0000, 3'd0, 48'd16000));
        send_event(build_event(16'h0000, 3'd0, 48'd16001));
        send_event(build_event(16'h1234, 3'd5, 48'd16001));
        send_event(build_event(16'h1234, 3'd6, 48'd16001));  // same index, other severity
        send_event(build_event(16'h1234, 3'd5, 48'd16002));
        s_tvalid <= 1'b0;
        clock_ms = 48'd16002;

        run_phase(32'd200, 32'd1000, 220, 150, 10, '0, 1'b0);
        run_phase(32'd0, 32'd0, 200, 3, 10, '0, 1'b0);
        // nothing expires: the table overflows
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 220, 1000, 45, '0, 1'b0);
        // jump past the pending sweep so the full table gets cleared
        run_phase(32'd1000, 32'd0, 200, 800, 15, 48'h2_0000_0000, 1'b0);
        run_phase(32'($urandom_range(1, 4000)), 32'($urandom_range(1, 20000)),
                  200, 3000, 15, '0, 1'b0);
        run_phase(32'($urandom), 32'($urandom), 200, 32'h0010_0000, 20, '0, 1'b1);

        // top of the time range: sweep time saturates
        drain();
        write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(build_event(16'h0005, 3'd2, 48'hFFFF_FFFF_FFFE));
        send_event(build_event(16'h0005, 3'd2, 48'hFFFF_FFFF_FFFF));
        send_event(build_event(16'h0009, 3'd1, 48'hFFFF_FFFF_FFFF));
        send_event(build_event(16'h0009, 3'd1, 48'hFFFF_FFFF_FFFF));
        send_event(build_event(16'h0005, 3'd2, 48'd0));
        s_tvalid <= 1'b0;

        drain();
        repeat (SLOTS + 8)
            @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/arsf_pkg.sv
rtl/core/arsf_ram.sv
rtl/core/arsf_engine.sv
rtl/core/alarm_repeat_suppression_filter.sv
verif/alarm_repeat_suppression_filter_tb.sv
